// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define MRCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define MRCA_ASSERT_IMP(lbl, ante, cons, msg) \
  `MRCA_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define MRCA_ASSERT_NXT(lbl, ante, cons, msg) \
  `MRCA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/mrca_pkg.sv =====
`default_nettype none

package mrca_pkg;

  // result field widths
  localparam int LINE_W     = 10;
  localparam int AVG_W      = 24;
  localparam int FRAC_BITS  = 8;

  // configuration port
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic acc;
    logic start_row;
    logic start_col;
    logic emit_row;
    logic emit_col;
  } mrca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_end;
    logic mat_end;
    logic div_done;
    logic out_free;
  } mrca_status_t;

endpackage

`default_nettype wire

// ===== rtl/mrca_intf.sv =====
`default_nettype none

// element request channel
interface mrca_elem_if #(
  parameter int ELEMENT_WIDTH = 16
) ();
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// average request channel
interface mrca_avg_if
  import mrca_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    is_column;
  logic [LINE_W-1:0]       line_index;
  logic signed [AVG_W-1:0] average;
  logic                    last;

  modport source (output valid, output is_column, output line_index, output average,
                  output last, input ready);
  modport sink   (input valid, input is_column, input line_index, input average,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/mrca_ram.sv =====
`default_nettype none

module mrca_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mrca_div.sv =====
`default_nettype none

module mrca_div
  import mrca_pkg::*;
#(
  parameter int SUM_W = 27,
  parameter int CNT_W = 11
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] sum,
  input  wire logic [CNT_W-1:0]        count,
  output logic                         done,
  output logic signed [AVG_W-1:0]      avg
);

  localparam int NW = SUM_W + FRAC_BITS;
  localparam int QW = (NW > AVG_W + 1) ? NW : AVG_W + 1;
  localparam int KW = $clog2(NW + 1);
  localparam logic [QW-1:0] POS_LIM = QW'(2 ** (AVG_W - 1) - 1);
  localparam logic [QW-1:0] NEG_LIM = QW'(2 ** (AVG_W - 1));

  logic             busy;
  logic             fin;
  logic [KW-1:0]    cnt;
  logic             neg;
  logic [NW-1:0]    dvd;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W-1:0] rem;
  logic [NW-1:0]    quo;

  logic [SUM_W-1:0] mag;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;
  logic [QW-1:0]    qx;
  logic [AVG_W-1:0] avg_sat;

  // magnitude, most negative value maps to 2^(SUM_W-1)
  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // one restoring step per cycle
  assign trial = {rem, dvd[NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  // sign restore and clip to the result range
  assign qx = QW'(quo);
  always_comb begin
    if (!neg) begin
      avg_sat = (qx > POS_LIM) ? AVG_W'(POS_LIM) : AVG_W'(qx);
    end else begin
      avg_sat = (qx > NEG_LIM) ? AVG_W'(NEG_LIM) : AVG_W'(QW'(0) - qx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KW'(NW);
      end else if (busy) begin
        cnt <= cnt - KW'(1);
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= sum[SUM_W-1];
      dvd <= {mag, FRAC_BITS'(0)};
      dvs <= count;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[NW-2:0], 1'b0};
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[NW-2:0], ge};
    end
    if (fin) begin
      avg <= avg_sat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mrca_dp.sv =====
`default_nettype none

module mrca_dp
  import mrca_pkg::*;
#(
  parameter int MAX_COLS      = 32,
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0]           cfg_data,
  input  wire logic signed [ELEMENT_WIDTH-1:0] element,
  input  wire mrca_cmd_t                       cmd,
  output mrca_status_t                         status,
  mrca_avg_if.source                           out_ch
);

  localparam int CPW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RPW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW    = $clog2(MAX_COLS + 1);
  localparam int RCW    = $clog2(MAX_ROWS + 1);
  localparam int RSUM_W = ELEMENT_WIDTH + CCW;
  localparam int CSUM_W = ELEMENT_WIDTH + RCW;
  localparam int SW     = (RSUM_W > CSUM_W) ? RSUM_W : CSUM_W;
  localparam int DVW    = (RCW > CCW) ? RCW : CCW;

  logic [ROWS_CFG_W-1:0]           row_count;
  logic [COLS_CFG_W-1:0]           col_count;
  logic [RCW-1:0]                  rows_eff;
  logic [CCW-1:0]                  cols_eff;

  logic [RPW-1:0]                  row_pos;
  logic [CPW-1:0]                  col_pos;
  logic signed [RSUM_W-1:0]        row_sum;
  logic signed [ELEMENT_WIDTH-1:0] elem_q;

  logic signed [CSUM_W-1:0]        ram_wdata;
  logic signed [CSUM_W-1:0]        ram_rdata;

  logic signed [SW-1:0]            div_sum;
  logic [DVW-1:0]                  div_cnt;
  logic                            div_done;
  logic signed [AVG_W-1:0]         div_avg;

  logic                            out_vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROWS_CFG_W'(1);
      col_count <= COLS_CFG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count <= cfg_data[ROWS_CFG_W-1:0];
        CFG_COL_COUNT: col_count <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // counts clipped to 1..max
  always_comb begin
    if (row_count == '0) begin
      rows_eff = RCW'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(row_count);
    end
    if (col_count == '0) begin
      cols_eff = CCW'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(col_count);
    end
  end

  assign status.line_end = (int'(col_pos) + 1 >= int'(cols_eff));
  assign status.mat_end  = (int'(row_pos) + 1 >= int'(rows_eff));
  assign status.div_done = div_done;
  assign status.out_free = !out_vld || out_ch.ready;

  // column sums, first row overwrites
  assign ram_wdata = (row_pos == '0) ? CSUM_W'(elem_q) : ram_rdata + CSUM_W'(elem_q);

  mrca_ram #(
    .WIDTH (CSUM_W),
    .DEPTH (MAX_COLS)
  ) u_col_ram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (col_pos),
    .wdata (ram_wdata),
    .raddr (col_pos),
    .rdata (ram_rdata)
  );

  assign div_sum = cmd.start_row ? SW'(row_sum) : SW'(ram_rdata);
  assign div_cnt = cmd.start_row ? DVW'(cols_eff) : DVW'(rows_eff);

  mrca_div #(
    .SUM_W (SW),
    .CNT_W (DVW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_row || cmd.start_col),
    .sum   (div_sum),
    .count (div_cnt),
    .done  (div_done),
    .avg   (div_avg)
  );

  // positions and row sum
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      row_sum <= '0;
    end else begin
      if (cmd.acc) begin
        row_sum <= row_sum + RSUM_W'(elem_q);
        if (!status.line_end) begin
          col_pos <= col_pos + CPW'(1);
        end
      end
      if (cmd.emit_row) begin
        row_sum <= '0;
        col_pos <= '0;
        row_pos <= status.mat_end ? '0 : row_pos + RPW'(1);
      end
      if (cmd.emit_col) begin
        col_pos <= status.line_end ? '0 : col_pos + CPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      elem_q <= element;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.emit_row || cmd.emit_col) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_row || cmd.emit_col) begin
      out_ch.is_column  <= cmd.emit_col;
      out_ch.line_index <= cmd.emit_row ? LINE_W'(row_pos) : LINE_W'(col_pos);
      out_ch.average    <= div_avg;
      out_ch.last       <= cmd.emit_col && status.line_end;
    end
  end

  assign out_ch.valid = out_vld;

endmodule

`default_nettype wire

// ===== rtl/mrca_ctrl.sv =====
`default_nettype none

module mrca_ctrl
  import mrca_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire mrca_status_t status,
  output mrca_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_RDIV  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_CRD   = 3'd5;
  localparam logic [2:0] S_CWAIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       col_phase;
  logic       col_phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    col_phase_next = col_phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.line_end ? S_RDIV : S_IDLE;
      end
      S_RDIV: begin
        cmd.start_row  = 1'b1;
        col_phase_next = 1'b0;
        state_next     = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          if (col_phase) begin
            cmd.emit_col = 1'b1;
            state_next   = status.line_end ? S_IDLE : S_CRD;
          end else begin
            cmd.emit_row = 1'b1;
            state_next   = status.mat_end ? S_CRD : S_IDLE;
          end
        end
      end
      // column sum read goes through the ram's read register
      S_CRD: begin
        state_next = S_CWAIT;
      end
      S_CWAIT: begin
        cmd.start_col  = 1'b1;
        col_phase_next = 1'b1;
        state_next     = S_DIV;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col_phase <= 1'b0;
    end else begin
      state     <= state_next;
      col_phase <= col_phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/matrix_row_column_averager.sv =====
// matrix row and column averager. elements arrive one request at a time in row-major
// order on in_ch; row_count and col_count (config indexes 0 and 1, zero treated as one,
// values above MAX_ROWS / MAX_COLS clipped) set the matrix shape. each row end produces
// one row average on out_ch; the last row is followed by every column average in column
// order, the final one flagged with last. averages are signed fixed point with 8 fraction
// bits, sum*256/count truncated toward zero and clipped to 24 bits. an element that does
// not end a row is accepted, then its column sum is read, modified and written in a ram
// with one read and one write port. a row end adds one shared bit-serial divide over the
// widest sum (27 bits at defaults), then the load of the output register. the matrix end
// then adds, per column, a column sum read, one divide and one load. the output register
// lets the next element request be taken while a result still waits on out_ch.
`default_nettype none
`include "assert_macros.svh"

module matrix_row_column_averager
  import mrca_pkg::*;
#(
  parameter int MAX_COLS      = 32,
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  mrca_elem_if.sink                  in_ch,
  mrca_avg_if.source                 out_ch
);

  mrca_cmd_t    cmd;
  mrca_status_t status;
  logic         in_ready;

  // element requests are taken only by the controller's idle state
  assign in_ch.ready = in_ready;

  // sequencing: accept, accumulate, divide, load result, column burst
  mrca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // config registers, positions, sums, column ram, divider, output register
  mrca_dp #(
    .MAX_COLS      (MAX_COLS),
    .MAX_ROWS      (MAX_ROWS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .element   (in_ch.element),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

  // at most one datapath command per cycle
  `MRCA_ASSERT(a_one_cmd, $onehot0(cmd), "more than one datapath command")
  // every accepted element is accumulated in the next cycle
  `MRCA_ASSERT_NXT(a_acc_after_accept, cmd.accept, cmd.acc, "accept not followed by acc")
  // a pending result is never overwritten
  `MRCA_ASSERT_IMP(a_no_overwrite, cmd.emit_row || cmd.emit_col, status.out_free,
                   "output register overwritten")
  // last only marks a column average
  `MRCA_ASSERT_IMP(a_last_is_col, out_ch.valid && out_ch.last, out_ch.is_column,
                   "last set on a row average")

endmodule

`default_nettype wire

// ===== tb/mrca_average_checker.sv =====
`timescale 1ns / 1ps

module mrca_average_checker
  import mrca_pkg::*;
#(
  parameter int MAX_COLS      = 32,
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mrca_elem_if                  in_ch,
  mrca_avg_if                   out_ch,
  output int                    mismatches,
  output int                    awaited
);

  localparam int     ROW_SUM_W = 22;
  localparam int     COL_SUM_W = 27;
  localparam int     COL_POS_W = $clog2(MAX_COLS);
  localparam longint AVG_HI    = (longint'(1) <<< (AVG_W - 1)) - 1;
  localparam longint AVG_LO    = -(longint'(1) <<< (AVG_W - 1));

  typedef struct {
    logic                    is_column;
    logic [LINE_W-1:0]       line_index;
    logic signed [AVG_W-1:0] average;
    logic                    last;
  } average_t;

  average_t pending_averages[$];

  logic [ROWS_CFG_W-1:0]       rows_reg;
  logic [COLS_CFG_W-1:0]       cols_reg;
  logic [LINE_W-1:0]           row_pos;
  logic [COL_POS_W-1:0]        col_pos;
  logic signed [ROW_SUM_W-1:0] row_sum;
  logic signed [COL_SUM_W-1:0] column_sums [MAX_COLS];

  // zero acts as one, anything above the cap is clipped
  function automatic int effective_count(int raw, int cap);
    if (raw == 0) return 1;
    return (raw > cap) ? cap : raw;
  endfunction

  // q.8 mean, truncated toward zero, clipped to the result width
  function automatic logic signed [AVG_W-1:0] q8_mean(longint sum, int count);
    longint q;
    q = (sum * (longint'(1) <<< FRAC_BITS)) / longint'(count);
    if (q > AVG_HI) q = AVG_HI;
    if (q < AVG_LO) q = AVG_LO;
    return q[AVG_W-1:0];
  endfunction

  task automatic absorb_element(input logic signed [ELEMENT_WIDTH-1:0] x);
    int rows;
    int cols;
    rows = effective_count(int'(rows_reg), MAX_ROWS);
    cols = effective_count(int'(cols_reg), MAX_COLS);
    row_sum = row_sum + x;
    if (row_pos == 0) column_sums[col_pos] = x;
    else column_sums[col_pos] = column_sums[col_pos] + x;
    if (int'(col_pos) + 1 < cols) begin
      col_pos = col_pos + 1'b1;
      return;
    end
    pending_averages.push_back('{is_column: 1'b0, line_index: row_pos,
                                 average: q8_mean(row_sum, cols), last: 1'b0});
    row_sum = '0;
    col_pos = '0;
    if (int'(row_pos) + 1 < rows) begin
      row_pos = row_pos + 1'b1;
      return;
    end
    // matrix done: column means follow the last row mean
    for (int j = 0; j < cols; j++) begin
      pending_averages.push_back('{is_column: 1'b1, line_index: LINE_W'(j),
                                   average: q8_mean(column_sums[j], rows),
                                   last: (j + 1 == cols)});
    end
    row_pos = '0;
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    average_t want;
    if (rst) begin
      rows_reg = ROWS_CFG_W'(1);
      cols_reg = COLS_CFG_W'(1);
      row_pos  = '0;
      col_pos  = '0;
      row_sum  = '0;
      pending_averages.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_averages.size() == 0) begin
          mismatches++;
          $display("%0t: average none awaited, expected nothing got col %0d line %0d avg %0d last %0d",
                   $time, out_ch.is_column, out_ch.line_index, out_ch.average, out_ch.last);
        end else begin
          want = pending_averages.pop_front();
          check_field("is_column", want.is_column, out_ch.is_column);
          check_field("line_index", want.line_index, out_ch.line_index);
          check_field("average", want.average, out_ch.average);
          check_field("last", want.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) absorb_element(in_ch.element);
      if (cfg_write) begin
        if (cfg_index == CFG_ROW_COUNT) rows_reg = cfg_data[ROWS_CFG_W-1:0];
        else if (cfg_index == CFG_COL_COUNT) cols_reg = cfg_data[COLS_CFG_W-1:0];
      end
    end
    awaited = pending_averages.size();
  end

endmodule

// ===== tb/tb_matrix_row_column_averager.sv =====
`timescale 1ns / 1ps

module tb_matrix_row_column_averager;
  import mrca_pkg::*;

  localparam int MAX_COLS      = 32;
  localparam int MAX_ROWS      = 1024;
  localparam int ELEMENT_WIDTH = 16;

  // indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MAX = 16'sh7fff;
  localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MIN = 16'sh8000;

  localparam int RANDOM_ITEMS = 440;
  localparam int CALM_FROM    = 340;  // no idling past this many random requests
  localparam int DRAIN_CYCLES = 64;   // longer than one divide plus output load

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm = 1'b0;
  int                    mismatches;
  int                    awaited;
  int                    random_sent;

  mrca_elem_if #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) in_ch ();
  mrca_avg_if out_ch ();

  always #5 clk = ~clk;

  matrix_row_column_averager #(
    .MAX_COLS      (MAX_COLS),
    .MAX_ROWS      (MAX_ROWS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  mrca_average_checker #(
    .MAX_COLS      (MAX_COLS),
    .MAX_ROWS      (MAX_ROWS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // result side: random stall bursts, none once calm
  initial begin : average_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog, far above the slowest legal run
  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // same clipping the block applies, used only to size a matrix
  function automatic int shape_span(int raw, int cap);
    if (raw == 0) return 1;
    return (raw > cap) ? cap : raw;
  endfunction

  // mostly full-range values, with the extremes and tiny values mixed in
  function automatic logic signed [ELEMENT_WIDTH-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return ELEM_MAX;
      1:       return ELEM_MIN;
      2:       return ELEMENT_WIDTH'($signed($urandom_range(0, 8)) - 4);
      default: return ELEMENT_WIDTH'($urandom);
    endcase
  endfunction

  // one element request, with an optional idle burst in front
  task automatic send_element(input logic signed [ELEMENT_WIDTH-1:0] value);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.element <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait for every awaited average, then let the datapath go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_write after its last one
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic set_shape(input int rows_raw, input int cols_raw);
    cfg_put(CFG_ROW_COUNT, rows_raw);
    cfg_put(CFG_COL_COUNT, cols_raw);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int rows_raw;
    int cols_raw;
    int span;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_ROW_COUNT;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.element = '0;
    random_sent   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset shape is 1 x 1: every element is a whole matrix
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    settle();

    // writes to unused indexes leave the shape alone
    cfg_put(CFG_SPARE_A, 11'h7ff);
    cfg_put(CFG_SPARE_B, 11'h005);
    cfg_write <= 1'b0;
    send_element('0);
    settle();

    // zero counts behave as one
    set_shape(0, 0);
    send_element(-1);
    settle();

    // thirds that do not divide evenly, truncated toward zero both ways
    set_shape(1, 3);
    send_element(1);
    send_element(0);
    send_element(0);
    send_element(-1);
    send_element(0);
    send_element(0);
    settle();

    // extreme rows, column sums that cancel or nearly cancel
    set_shape(2, 3);
    repeat (3) send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    send_element(ELEM_MIN);
    send_element(-ELEM_MAX);
    settle();

    // one column of the most negative element: row and column means land
    // on the most negative value the result can hold
    set_shape(4, 0);
    repeat (4) send_element(ELEM_MIN);
    settle();

    // random matrices, shapes mostly small with the odd wide or clipped one
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          rows_raw = 0;
          cols_raw = $urandom_range(MAX_COLS + 1, 63);
        end
        1: begin
          rows_raw = $urandom_range(1, 3);
          cols_raw = MAX_COLS;
        end
        2: begin
          rows_raw = 1;
          cols_raw = $urandom_range(1, MAX_COLS);
        end
        3: begin
          rows_raw = $urandom_range(1, 12);
          cols_raw = 0;
        end
        default: begin
          rows_raw = $urandom_range(1, 5);
          cols_raw = $urandom_range(1, 8);
        end
      endcase
      calm = (random_sent >= CALM_FROM);
      span = shape_span(rows_raw, MAX_ROWS) * shape_span(cols_raw, MAX_COLS);
      set_shape(rows_raw, cols_raw);
      repeat (span) send_element(pick_element());
      random_sent += span;
      settle();
    end

    if (mismatches == 0 && awaited == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mrca_pkg.sv
rtl/mrca_intf.sv
rtl/mrca_ram.sv
rtl/mrca_div.sv
rtl/mrca_dp.sv
rtl/mrca_ctrl.sv
rtl/matrix_row_column_averager.sv
tb/mrca_average_checker.sv
tb/tb_matrix_row_column_averager.sv
